/* design/cop0rt_pkg.sv */
package cop0rt_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned INDEX_W  = 5;
    localparam int unsigned CYCLES_W = 16;
    localparam int unsigned NUM_REGS = 32;

    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    localparam logic [INDEX_W-1:0] REG_COUNT     = 5'd9;
    localparam logic [INDEX_W-1:0] REG_COMPARE   = 5'd11;
    localparam logic [INDEX_W-1:0] REG_STATUS    = 5'd12;
    localparam logic [INDEX_W-1:0] REG_CAUSE     = 5'd13;
    localparam logic [INDEX_W-1:0] REG_EPC       = 5'd14;
    localparam logic [INDEX_W-1:0] REG_PRID      = 5'd15;
    localparam logic [INDEX_W-1:0] REG_ERROR_EPC = 5'd30;

    localparam logic [DATA_W-1:0] STATUS_MASK  = 32'hF0C7_9C1F;
    localparam logic [DATA_W-1:0] STATUS_RESET = 32'h7040_0000;
    localparam logic [DATA_W-1:0] REVISION_ID  = 32'h0000_2E20;

    localparam int unsigned PERF_ENABLE_BIT = 31;
    localparam int unsigned CAUSE_TIMER_BIT = 15;

    typedef logic [DATA_W-1:0]   word_t;
    typedef logic [INDEX_W-1:0]  index_t;
    typedef logic [CYCLES_W-1:0] cycles_t;

    // Event codes for which a performance counter advances.
    function automatic logic event_counts(input logic [4:0] ev);
        logic hit;
        begin
            hit = (ev == 5'd1) || (ev == 5'd2) || (ev == 5'd3) ||
                  ((ev >= 5'd12) && (ev <= 5'd15));
            return hit;
        end
    endfunction

endpackage

/* design/cop0rt_req_if.sv */
interface cop0rt_req_if;
    logic                      valid;
    logic                      ready;
    cop0rt_pkg::op_t           op;
    cop0rt_pkg::index_t        reg_index;
    cop0rt_pkg::word_t         write_value;
    cop0rt_pkg::cycles_t       cycles;

    modport source (output valid, output op, output reg_index, output write_value,
                    output cycles, input ready);
    modport sink   (input valid, input op, input reg_index, input write_value,
                    input cycles, output ready);
endinterface

/* design/cop0rt_rsp_if.sv */
interface cop0rt_rsp_if;
    logic                valid;
    logic                ready;
    cop0rt_pkg::word_t   read_data;
    logic                timer_pending;
    cop0rt_pkg::word_t   perf_count0;
    cop0rt_pkg::word_t   perf_count1;

    modport source (output valid, output read_data, output timer_pending,
                    output perf_count0, output perf_count1, input ready);
    modport sink   (input valid, input read_data, input timer_pending,
                    input perf_count0, input perf_count1, output ready);
endinterface

/* design/cop0_register_timer_perf.sv */
// A transaction accepted into the input register moves to the result register, where its
// result is valid. Throughput: one transaction per cycle unless rsp.ready stalls a result;
// an input register and a result register bound the single pass of register access, timer
// update and counter update. Reset (rst_n, asynchronous, active low) clears both stages,
// the timer flag, the counters and the exception PCs, loads Status with its default and the
// register file with zero, apart from the revision identifier.
module cop0_register_timer_perf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 perf_control_we,
    input  cop0rt_pkg::word_t    perf_control_wdata,
    cop0rt_req_if.sink           req,
    cop0rt_rsp_if.source         rsp
);

    // Input stage.
    logic                  s1_valid_reg;
    cop0rt_pkg::op_t       s1_op_reg;
    cop0rt_pkg::index_t    s1_index_reg;
    cop0rt_pkg::word_t     s1_value_reg;
    cop0rt_pkg::cycles_t   s1_cycles_reg;

    // Architectural state.
    cop0rt_pkg::word_t     gpr_reg [cop0rt_pkg::NUM_REGS];
    cop0rt_pkg::word_t     status_reg;
    cop0rt_pkg::word_t     epc_reg;
    cop0rt_pkg::word_t     error_epc_reg;
    logic                  timer_flag_reg;
    cop0rt_pkg::word_t     perf0_reg;
    cop0rt_pkg::word_t     perf1_reg;
    cop0rt_pkg::word_t     perf_control_reg;

    cop0rt_pkg::word_t     status_next;
    cop0rt_pkg::word_t     epc_next;
    cop0rt_pkg::word_t     error_epc_next;
    logic                  timer_flag_next;
    cop0rt_pkg::word_t     perf0_next;
    cop0rt_pkg::word_t     perf1_next;

    // Result stage.
    logic                  out_valid_reg;
    cop0rt_pkg::word_t     out_read_data_reg;
    cop0rt_pkg::word_t     read_data_next;

    logic                  s1_advance;
    logic                  s1_fire;
    logic                  gpr_we;
    cop0rt_pkg::index_t    gpr_waddr;
    cop0rt_pkg::word_t     gpr_wdata;

    cop0rt_pkg::word_t     count_sum;
    logic [1:0]            mode;
    logic [4:0]            gate;
    logic                  perf_on;
    logic                  hit0;
    logic                  hit1;

    assign s1_advance = !out_valid_reg || rsp.ready;
    assign s1_fire    = s1_valid_reg && s1_advance;
    assign req.ready  = !s1_valid_reg || s1_advance;

    assign count_sum = gpr_reg[cop0rt_pkg::REG_COUNT] + {16'd0, s1_cycles_reg};
    assign mode      = status_reg[4:3];
    assign gate      = {4'b0001 << mode, status_reg[1]};
    assign perf_on   = perf_control_reg[cop0rt_pkg::PERF_ENABLE_BIT];
    assign hit0      = perf_on && (|(perf_control_reg[5:1] & gate)) &&
                       cop0rt_pkg::event_counts(perf_control_reg[9:5]);
    assign hit1      = perf_on && (|(perf_control_reg[15:11] & gate)) &&
                       cop0rt_pkg::event_counts(perf_control_reg[19:15]);

    always_comb
    begin
        status_next     = status_reg;
        epc_next        = epc_reg;
        error_epc_next  = error_epc_reg;
        timer_flag_next = timer_flag_reg;
        perf0_next      = perf0_reg;
        perf1_next      = perf1_reg;
        read_data_next  = '0;
        gpr_we          = 1'b0;
        gpr_waddr       = s1_index_reg;
        gpr_wdata       = s1_value_reg;
        if (s1_fire)
        begin
            unique case (s1_op_reg)
                cop0rt_pkg::OP_READ:
                begin
                    unique case (s1_index_reg)
                        cop0rt_pkg::REG_STATUS:    read_data_next = status_reg;
                        cop0rt_pkg::REG_CAUSE:
                            read_data_next = {16'd0, timer_flag_reg, 15'd0};
                        cop0rt_pkg::REG_EPC:       read_data_next = epc_reg;
                        cop0rt_pkg::REG_ERROR_EPC: read_data_next = error_epc_reg;
                        default:                   read_data_next = gpr_reg[s1_index_reg];
                    endcase
                end
                cop0rt_pkg::OP_WRITE:
                begin
                    unique case (s1_index_reg)
                        cop0rt_pkg::REG_STATUS:
                            status_next = s1_value_reg & cop0rt_pkg::STATUS_MASK;
                        cop0rt_pkg::REG_CAUSE:     ;
                        cop0rt_pkg::REG_EPC:       epc_next = s1_value_reg;
                        cop0rt_pkg::REG_ERROR_EPC: error_epc_next = s1_value_reg;
                        cop0rt_pkg::REG_COMPARE:
                        begin
                            timer_flag_next = 1'b0;
                            gpr_we          = 1'b1;
                        end
                        default:                   gpr_we = 1'b1;
                    endcase
                end
                cop0rt_pkg::OP_TICK:
                begin
                    if ((gpr_reg[cop0rt_pkg::REG_COUNT] < gpr_reg[cop0rt_pkg::REG_COMPARE]) &&
                        (count_sum >= gpr_reg[cop0rt_pkg::REG_COMPARE]))
                    begin
                        timer_flag_next = 1'b1;
                    end
                    gpr_we    = 1'b1;
                    gpr_waddr = cop0rt_pkg::REG_COUNT;
                    gpr_wdata = count_sum;
                    if (hit0)
                    begin
                        perf0_next = perf0_reg + {16'd0, s1_cycles_reg};
                    end
                    if (hit1)
                    begin
                        perf1_next = perf1_reg + {16'd0, s1_cycles_reg};
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            status_reg       <= cop0rt_pkg::STATUS_RESET;
            epc_reg          <= '0;
            error_epc_reg    <= '0;
            timer_flag_reg   <= 1'b0;
            perf0_reg        <= '0;
            perf1_reg        <= '0;
            perf_control_reg <= '0;
            for (int i = 0; i < cop0rt_pkg::NUM_REGS; i++)
            begin
                gpr_reg[i] <= (i == int'(cop0rt_pkg::REG_PRID)) ?
                              cop0rt_pkg::REVISION_ID : '0;
            end
        end
        else
        begin
            if (req.ready)
            begin
                s1_valid_reg <= req.valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (perf_control_we)
            begin
                perf_control_reg <= perf_control_wdata;
            end
            status_reg     <= status_next;
            epc_reg        <= epc_next;
            error_epc_reg  <= error_epc_next;
            timer_flag_reg <= timer_flag_next;
            perf0_reg      <= perf0_next;
            perf1_reg      <= perf1_next;
            if (gpr_we)
            begin
                gpr_reg[gpr_waddr] <= gpr_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            s1_op_reg     <= req.op;
            s1_index_reg  <= req.reg_index;
            s1_value_reg  <= req.write_value;
            s1_cycles_reg <= req.cycles;
        end
        if (s1_fire)
        begin
            out_read_data_reg <= read_data_next;
        end
    end

    // The flag, counters and register file are only updated as a transaction moves to the
    // result stage, so the result stage can show them directly.
    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = out_read_data_reg;
    assign rsp.timer_pending = timer_flag_reg;
    assign rsp.perf_count0   = perf0_reg;
    assign rsp.perf_count1   = perf1_reg;

`ifndef ASSERT_OFF
    a_compare_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_op_reg == cop0rt_pkg::OP_WRITE) &&
         (s1_index_reg == cop0rt_pkg::REG_COMPARE)) |=> !timer_flag_reg)
        else $error("timer flag not cleared by a Compare write");

    a_flag_rises_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(timer_flag_reg) |-> $past(s1_fire && (s1_op_reg == cop0rt_pkg::OP_TICK)))
        else $error("timer flag set without a tick");

    a_counters_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_fire && (s1_op_reg == cop0rt_pkg::OP_TICK)) |=>
        ($stable(perf0_reg) && $stable(perf1_reg)))
        else $error("performance counter changed without a tick");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> (out_valid_reg && $stable(timer_flag_reg) &&
                                           $stable(perf0_reg) && $stable(perf1_reg)))
        else $error("state moved while a result was stalled");
`endif

endmodule
